/* hw/rtl/vu_meter_pixel_renderer_assert.svh */
// Assertion macros used by the checker file of the VU meter renderer.
// Each macro expects clk and rst to be visible where it is used.
`ifndef VU_METER_PIXEL_RENDERER_ASSERT_SVH
`define VU_METER_PIXEL_RENDERER_ASSERT_SVH

// Same-cycle implication.
`define VMPR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VMPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/vmpr_pkg.sv */
`timescale 1ns / 1ps

package vmpr_pkg;

  // Width of a quotient coming out of the shared multiply and divide-by-255 unit.
  localparam int unsigned QUOT_W = 10;

  // x / 255 == (x * RECIP_255) >> RECIP_SHIFT for every x below 2**18.
  localparam logic [18:0] RECIP_255   = 19'd263173;
  localparam int unsigned RECIP_SHIFT = 26;

  // x / 3 == (x * THIRD_MUL) >> THIRD_SHIFT for every 8-bit x.
  localparam logic [8:0]  THIRD_MUL   = 9'd171;
  localparam int unsigned THIRD_SHIFT = 9;

  localparam logic [7:0] FULL_LEVEL = 8'd255;
  localparam logic [7:0] PEAK_STEP  = 8'd2;
  localparam logic [7:0] GLOW_STEP  = 8'd12;
  localparam logic [7:0] HALO_DIM   = 8'd80;
  localparam logic [7:0] GREY_LEVEL = 8'd96;

  typedef enum logic [2:0] {
    REG_STRIP_LENGTH     = 3'd0,
    REG_PRIMARY_COLOR    = 3'd1,
    REG_SECONDARY_COLOR  = 3'd2,
    REG_BACKGROUND_COLOR = 3'd3,
    REG_POWER_ON         = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

endpackage

/* hw/rtl/vu_meter_pixel_renderer.sv */
`timescale 1ns / 1ps

// Mirrored center VU meter renderer for an RGBW strip with peak hold and beat glow. A frame
// request (operation 0) on a non-empty, powered strip updates peak hold and beat glow at
// once, then latches the bar half-length; it produces no result. A pixel request
// (operation 1) returns one color. An out-of-range pixel, or any pixel while power is off,
// skips to a black result. Otherwise the peak marker offset comes first; a halo pixel then
// gets a dimmed blend, and a bar pixel gets 8 divider steps when the bar is non-empty,
// a blend and the beat tint while the glow is lit. One shared two-stage unit (an 8x10-bit
// multiply and an exact divide by 255 through a reciprocal multiply) takes one channel
// product per cycle; a one-bit-per-cycle restoring divider gives the blend position.
// The input is not ready while a request is being worked on. The finished color sits in an
// output register, so a new request can be taken while the previous result still waits for
// out_ready.
module vu_meter_pixel_renderer #(
  parameter int unsigned MAX_PIXELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  volume,
  input  logic        beat,
  input  logic [9:0]  pixel_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  white,
  output logic        out_of_range
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRM,
    S_PK,
    S_SEL,
    S_DIV,
    S_BLEND,
    S_GLOW,
    S_HALO,
    S_DONE
  } state_t;

  // Configuration registers.
  logic [10:0] strip_length;
  logic [31:0] primary_color;
  logic [31:0] secondary_color;
  logic [31:0] background_color;
  logic        power_on;

  // Meter state.
  logic [7:0]  peak_level;
  logic [7:0]  glow_level;
  logic        frame_parity;
  logic [9:0]  bar_length;

  // Sequencer and per-request working registers.
  state_t      state;
  logic [3:0]  cnt;
  logic [7:0]  vol_reg;
  logic [9:0]  idx_reg;
  logic [9:0]  pk;
  logic [7:0]  t;
  logic [17:0] rem;
  logic [16:0] dsr;
  logic [7:0]  gain;
  logic [7:0]  acc [4];
  logic        oor;

  // Shared multiply and divide-by-255 unit.
  logic [7:0]  mul_a;
  logic [9:0]  mul_b;
  logic [17:0] prod;
  logic [36:0] recip_prod;
  logic [9:0]  quot;

  logic [10:0] eff_len;
  logic [9:0]  half;
  logic [9:0]  d;
  logic [17:0] num;
  logic        rem_ge;
  logic [16:0] third_prod;
  logic [7:0]  glow_third;
  logic        halo_on;
  logic [7:0]  halo;
  logic        marker;
  logic [3:0]  j2;
  logic [1:0]  ch;
  logic        late;
  logic        idx_in_range;
  logic        out_load;

  function automatic logic [7:0] channel_byte(input logic [31:0] c, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = c[31:24];
      2'd1:    b = c[23:16];
      2'd2:    b = c[15:8];
      default: b = c[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  // Lengths above the build limit behave as the limit.
  assign eff_len = (32'(strip_length) > MAX_PIXELS) ? 11'(MAX_PIXELS) : strip_length;
  assign half    = eff_len[10:1];

  assign in_ready     = (state == S_IDLE);
  assign idx_in_range = ({1'b0, pixel_index} < eff_len);

  // The finished color moves into the output register once that register is free.
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Distance of the pixel from the center of the strip.
  assign d   = (idx_reg >= half) ? (idx_reg - half) : (half - idx_reg);
  assign num = {d, 8'd0} - {8'd0, d};

  assign rem_ge = (rem >= {1'b0, dsr});

  assign third_prod = 17'(glow_level) * 17'(vmpr_pkg::THIRD_MUL);
  assign glow_third = third_prod[vmpr_pkg::THIRD_SHIFT +: 8];

  assign halo_on = ({2'b0, glow_level} > d);
  assign halo    = glow_level - d[7:0];

  // With the marker strictly inside the half strip, matching either mirrored position is the
  // same as the distance equaling the marker offset.
  assign marker = (pk != 10'd0) && (pk < half) && (d == pk);

  // Results of the shared unit come back through its product and quotient registers.
  assign j2   = cnt - 4'd2;
  assign ch   = j2[1:0];
  assign late = j2[2];

  always_comb begin
    mul_a = peak_level;
    mul_b = half;
    unique case (state)
      S_FRM: begin
        mul_a = vol_reg;
        mul_b = half;
      end
      S_BLEND: begin
        if (!cnt[2]) begin
          mul_a = channel_byte(primary_color, cnt[1:0]);
          mul_b = {2'b0, vmpr_pkg::FULL_LEVEL - t};
        end else begin
          mul_a = channel_byte(secondary_color, cnt[1:0]);
          mul_b = {2'b0, t};
        end
      end
      S_GLOW: begin
        mul_a = channel_byte(secondary_color, cnt[1:0]);
        mul_b = {2'b0, gain};
      end
      S_HALO: begin
        if (!cnt[2]) begin
          mul_a = channel_byte(background_color, cnt[1:0]);
          mul_b = {2'b0, vmpr_pkg::HALO_DIM};
        end else begin
          mul_a = channel_byte(primary_color, cnt[1:0]);
          mul_b = {2'b0, gain};
        end
      end
      default: begin
        mul_a = peak_level;
        mul_b = half;
      end
    endcase
  end

  assign recip_prod = 37'(prod) * 37'(vmpr_pkg::RECIP_255);

  always_ff @(posedge clk) begin
    prod <= 18'(mul_a) * 18'(mul_b);
    quot <= recip_prod[vmpr_pkg::RECIP_SHIFT +: vmpr_pkg::QUOT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_length     <= 11'd64;
      primary_color    <= 32'd0;
      secondary_color  <= 32'd0;
      background_color <= 32'd0;
      power_on         <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vmpr_pkg::REG_STRIP_LENGTH:     strip_length     <= cfg_data[10:0];
        vmpr_pkg::REG_PRIMARY_COLOR:    primary_color    <= cfg_data;
        vmpr_pkg::REG_SECONDARY_COLOR:  secondary_color  <= cfg_data;
        vmpr_pkg::REG_BACKGROUND_COLOR: background_color <= cfg_data;
        vmpr_pkg::REG_POWER_ON:         power_on         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= 4'd0;
      peak_level   <= 8'd0;
      glow_level   <= 8'd0;
      frame_parity <= 1'b0;
      bar_length   <= 10'd0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (operation == vmpr_pkg::OP_FRAME) begin
              // An empty strip or a powered-down meter leaves all state frozen.
              if ((eff_len != 11'd0) && power_on) begin
                vol_reg <= volume;
                if (volume > peak_level) begin
                  peak_level <= volume;
                end else if (!frame_parity && (peak_level > vmpr_pkg::PEAK_STEP)) begin
                  peak_level <= peak_level - vmpr_pkg::PEAK_STEP;
                end
                if (beat) begin
                  glow_level <= vmpr_pkg::FULL_LEVEL;
                end else if (glow_level > vmpr_pkg::GLOW_STEP) begin
                  glow_level <= glow_level - vmpr_pkg::GLOW_STEP;
                end else begin
                  glow_level <= 8'd0;
                end
                frame_parity <= !frame_parity;
                cnt          <= 4'd0;
                state        <= S_FRM;
              end
            end else begin
              idx_reg <= pixel_index;
              if (idx_in_range && power_on) begin
                oor   <= 1'b0;
                cnt   <= 4'd0;
                state <= S_PK;
              end else begin
                oor    <= !idx_in_range;
                acc[0] <= 8'd0;
                acc[1] <= 8'd0;
                acc[2] <= 8'd0;
                acc[3] <= 8'd0;
                state  <= S_DONE;
              end
            end
          end
        end
        S_FRM: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd2) begin
            bar_length <= quot;
            state      <= S_IDLE;
          end
        end
        S_PK: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd2) begin
            pk    <= quot;
            state <= S_SEL;
          end
        end
        S_SEL: begin
          cnt <= 4'd0;
          if (marker) begin
            // The peak marker is the secondary color lifted by a grey on red, green and blue.
            acc[0] <= sat_add(channel_byte(secondary_color, 2'd0), vmpr_pkg::GREY_LEVEL);
            acc[1] <= sat_add(channel_byte(secondary_color, 2'd1), vmpr_pkg::GREY_LEVEL);
            acc[2] <= sat_add(channel_byte(secondary_color, 2'd2), vmpr_pkg::GREY_LEVEL);
            acc[3] <= channel_byte(secondary_color, 2'd3);
            state  <= S_DONE;
          end else if (d <= bar_length) begin
            gain <= glow_third;
            if (bar_length == 10'd0) begin
              t     <= 8'd0;
              state <= S_BLEND;
            end else begin
              rem   <= num;
              dsr   <= {bar_length, 7'd0};
              state <= S_DIV;
            end
          end else if (halo_on) begin
            gain  <= {2'b00, halo[7:2]};
            state <= S_HALO;
          end else begin
            acc[0] <= channel_byte(background_color, 2'd0);
            acc[1] <= channel_byte(background_color, 2'd1);
            acc[2] <= channel_byte(background_color, 2'd2);
            acc[3] <= channel_byte(background_color, 2'd3);
            state  <= S_DONE;
          end
        end
        S_DIV: begin
          // Restoring division of d*255 by the bar length, most significant bit first.
          if (rem_ge) begin
            rem <= rem - {1'b0, dsr};
          end
          dsr <= dsr >> 1;
          t   <= {t[6:0], rem_ge};
          cnt <= cnt + 4'd1;
          if (cnt == 4'd7) begin
            cnt   <= 4'd0;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          cnt <= cnt + 4'd1;
          if (cnt >= 4'd2) begin
            if (!late) begin
              acc[ch] <= quot[7:0];
            end else begin
              acc[ch] <= acc[ch] + quot[7:0];
            end
          end
          if (cnt == 4'd9) begin
            cnt   <= 4'd0;
            state <= (glow_level != 8'd0) ? S_GLOW : S_DONE;
          end
        end
        S_GLOW: begin
          cnt <= cnt + 4'd1;
          if (cnt >= 4'd2) begin
            acc[ch] <= sat_add(acc[ch], quot[7:0]);
          end
          if (cnt == 4'd5) begin
            cnt   <= 4'd0;
            state <= S_DONE;
          end
        end
        S_HALO: begin
          cnt <= cnt + 4'd1;
          if (cnt >= 4'd2) begin
            if (!late) begin
              acc[ch] <= quot[7:0];
            end else begin
              acc[ch] <= sat_add(acc[ch], quot[7:0]);
            end
          end
          if (cnt == 4'd9) begin
            cnt   <= 4'd0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            red          <= acc[0];
            green        <= acc[1];
            blue         <= acc[2];
            white        <= acc[3];
            out_of_range <= oor;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/vmpr_checker.sv */
`timescale 1ns / 1ps
`include "vu_meter_pixel_renderer_assert.svh"

module vmpr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       operation,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [7:0] white,
  input logic       out_of_range
);

  // A stalled result stays offered.
  `VMPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its color and range flag.
  `VMPR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(red) && $stable(green) && $stable(blue) && $stable(white) && $stable(out_of_range), "result changed while stalled")

  // A pixel request always leaves the block busy in the cycle after it is taken.
  `VMPR_ASSERT_NEXT(a_busy_after_pixel, in_valid && in_ready && (operation == vmpr_pkg::OP_PIXEL), !in_ready, "ready after pixel request")

  // A pixel beyond the strip is always black.
  `VMPR_ASSERT_IMPL(a_oor_black, out_valid && out_of_range, (red == 8'd0) && (green == 8'd0) && (blue == 8'd0) && (white == 8'd0), "out of range pixel not black")

endmodule

bind vu_meter_pixel_renderer vmpr_checker u_vmpr_checker (.*);
